@@ hdl/wrlm_pkg.sv @@
// Shared types and constants for the weighted region luma meter.
// Field widths, luma weights, register indexes, sequencer steps and control structs.
// No dependencies; every module of the block imports this package.
package wrlm_pkg;

    // payload and state widths
    localparam int SUM_W      = 37;
    localparam int CNT_W      = 24;
    localparam int WGT_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int GAIN_FRAC  = 16;
    localparam int WB_W       = 16;
    localparam int WB_FRAC    = 12;
    localparam int TOT_W      = 57;
    localparam int PIX_TOT_W  = 44;
    localparam int MEAN_W     = 20;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 4;

    // shared multiplier: A by B, product registered
    localparam int MA_W       = 40;
    localparam int MB_W       = 24;
    localparam int PROD_W     = 64;
    localparam int WBK_W      = 32;
    localparam int WBK_LO_W   = MB_W;
    localparam int ACC_W      = 91;
    localparam int SCALED_W   = SUM_W + GAIN_W - GAIN_FRAC;

    // dividend width after the smallest luma shift (pixel depth of 8)
    localparam int DVD_W      = ACC_W - WB_FRAC - 8;

    localparam logic [MEAN_W-1:0] MEAN_MAX       = '1;
    localparam logic [GAIN_W-1:0] TRIAL_GAIN_RST = 24'h01_0000;
    localparam logic [WB_W-1:0]   WB_GAIN_RST    = 16'h1000;

    // Rec.601 luma weights in Q0.16
    localparam logic [MB_W-1:0] LUMA_K_RED   = 24'd19595;
    localparam logic [MB_W-1:0] LUMA_K_GREEN = 24'd38470;
    localparam logic [MB_W-1:0] LUMA_K_BLUE  = 24'd7471;

    typedef enum logic [1:0] {
        REG_TRIAL_GAIN,
        REG_WB_RED,
        REG_WB_GREEN,
        REG_WB_BLUE
    } t_reg_idx;

    // sequencer step codes
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step IT_RED_SCALE   = 3'd0;
    localparam t_step IT_GREEN_SCALE = 3'd1;
    localparam t_step IT_RED_WEIGH   = 3'd2;
    localparam t_step IT_GREEN_WEIGH = 3'd3;
    localparam t_step IT_BLUE_SCALE  = 3'd4;
    localparam t_step IT_PIXELS      = 3'd5;
    localparam t_step IT_BLUE_WEIGH  = 3'd6;
    localparam t_step IT_BLUE_DONE   = 3'd7;

    localparam t_step MN_WBK_MUL     = 3'd0;
    localparam t_step MN_WBK_LATCH   = 3'd1;
    localparam t_step MN_LO_LO       = 3'd2;
    localparam t_step MN_LO_HI       = 3'd3;
    localparam t_step MN_HI_LO       = 3'd4;
    localparam t_step MN_HI_HI       = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITEM,
        ST_MEAN,
        ST_DRAIN,
        ST_DIV_START,
        ST_DIV,
        ST_PUT
    } t_state;

    typedef enum logic [1:0] {
        COL_RED,
        COL_GREEN,
        COL_BLUE
    } t_colour;

    typedef enum logic [2:0] {
        A_RED_SUM,
        A_GREEN_SUM,
        A_BLUE_SUM,
        A_CLIP,
        A_COUNT,
        A_WB,
        A_TOT_LO,
        A_TOT_HI
    } t_a_sel;

    typedef enum logic [2:0] {
        B_GAIN,
        B_WEIGHT,
        B_LUMA_K,
        B_WBK_LO,
        B_WBK_HI
    } t_b_sel;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_RED,
        WB_GREEN,
        WB_BLUE,
        WB_PIXELS
    } t_wb_sel;

    typedef enum logic [1:0] {
        SH_0,
        SH_24,
        SH_40,
        SH_64
    } t_shift;

    typedef struct packed {
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
        logic            acc_en;
        logic            acc_load;
        t_shift          shift;
    } t_mac_op;

    typedef struct packed {
        logic     in_ready;
        t_a_sel   a_sel;
        t_b_sel   b_sel;
        t_colour  col;
        logic     clip_en;
        t_wb_sel  wb_sel;
        logic     wbk_load;
        logic     acc_en;
        logic     acc_load;
        t_shift   shift;
        logic     div_start;
        logic     res_zero;
        logic     res_div;
        logic     clear;
        logic     out_load;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic last;
        logic wpt_zero;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

@@ hdl/wrlm_mac.sv @@
// Shared multiply-accumulate unit: registered 40x24 product, then a shifted add into a
// 91-bit accumulator in the following cycle. Depends on wrlm_pkg.
module wrlm_mac (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wrlm_pkg::t_mac_op              i_op,
    output logic [wrlm_pkg::PROD_W-1:0]    o_prod,
    output logic [wrlm_pkg::ACC_W-1:0]     o_acc
);
    import wrlm_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic              r_acc_en;
    logic              r_acc_load;
    t_shift            r_shift;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  addend;
    logic [ACC_W-1:0]  n_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_op.a) * PROD_W'(i_op.b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en   <= 1'b0;
            r_acc_load <= 1'b0;
            r_shift    <= SH_0;
        end else begin
            r_acc_en   <= i_op.acc_en;
            r_acc_load <= i_op.acc_load;
            r_shift    <= i_op.shift;
        end
    end

    always_comb begin
        unique case (r_shift)
            SH_0:  addend = ACC_W'(r_prod);
            SH_24: addend = ACC_W'(r_prod) << 24;
            SH_40: addend = ACC_W'(r_prod) << 40;
            SH_64: addend = ACC_W'(r_prod) << 64;
        endcase
        n_acc = (r_acc_load ? '0 : r_acc) + addend;
    end

    always_ff @(posedge i_clk) begin
        if (r_acc_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

@@ hdl/wrlm_div.sv @@
// Restoring divider, one quotient bit per cycle, 20-bit quotient with saturation.
// Depends on wrlm_pkg for widths.
module wrlm_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [wrlm_pkg::DVD_W-1:0]        i_dividend,
    input  logic [wrlm_pkg::PIX_TOT_W-1:0]    i_divisor,
    output logic                              o_done,
    output logic [wrlm_pkg::MEAN_W-1:0]       o_quot
);
    import wrlm_pkg::*;

    localparam int REM_W = PIX_TOT_W + MEAN_W;
    localparam int CNT_W_D = $clog2(MEAN_W);
    localparam logic [CNT_W_D-1:0] CNT_LAST = CNT_W_D'(MEAN_W - 1);

    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   r_dsh;
    logic [MEAN_W-1:0]  r_quot;
    logic [CNT_W_D-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [REM_W-1:0]   limit;
    logic               sat;
    logic [REM_W:0]     diff;
    logic               fits;

    always_comb begin
        limit = {i_divisor, {MEAN_W{1'b0}}};
        sat   = i_dividend >= DVD_W'(limit);
        diff  = {1'b0, r_rem} - {1'b0, r_dsh};
        fits  = !diff[REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= !sat;
                r_done <= sat;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend[REM_W-1:0];
            r_dsh  <= REM_W'(i_divisor) << (MEAN_W - 1);
            r_quot <= sat ? MEAN_MAX : '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= diff[REM_W-1:0];
            end
            r_dsh  <= r_dsh >> 1;
            r_quot <= {r_quot[MEAN_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ hdl/wrlm_ctrl.sv @@
// Sequencer for the luma meter: walks the item, mean and divide steps and drives
// the shared multiplier, write-back and result controls. Depends on wrlm_pkg.
module wrlm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrlm_pkg::t_status i_stat,
    output wrlm_pkg::t_ctrl   o_ctl
);
    import wrlm_pkg::*;

    t_state  r_state, n_state;
    t_step   r_step,  n_step;
    t_colour r_col,   n_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_col   <= COL_RED;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_col   <= n_col;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_col   = r_col;
        unique case (r_state)
            ST_IDLE: begin
                if (i_stat.in_valid) begin
                    n_state = ST_ITEM;
                    n_step  = IT_RED_SCALE;
                end
            end
            ST_ITEM: begin
                if (r_step == IT_BLUE_DONE) begin
                    n_step = IT_RED_SCALE;
                    if (i_stat.last) begin
                        n_col   = COL_RED;
                        n_state = i_stat.wpt_zero ? ST_PUT : ST_MEAN;
                    end else if (!i_stat.in_valid) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_MEAN: begin
                if (r_step == MN_HI_HI) begin
                    n_step = MN_WBK_MUL;
                    unique case (r_col)
                        COL_RED:   n_col = COL_GREEN;
                        COL_GREEN: n_col = COL_BLUE;
                        default:   n_state = ST_DRAIN;
                    endcase
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DRAIN:     n_state = ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV;
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctl = '{
            in_ready:  1'b0,
            a_sel:     A_RED_SUM,
            b_sel:     B_GAIN,
            col:       r_col,
            clip_en:   1'b0,
            wb_sel:    WB_NONE,
            wbk_load:  1'b0,
            acc_en:    1'b0,
            acc_load:  1'b0,
            shift:     SH_0,
            div_start: 1'b0,
            res_zero:  1'b0,
            res_div:   1'b0,
            clear:     1'b0,
            out_load:  1'b0
        };
        unique case (r_state)
            ST_IDLE: o_ctl.in_ready = 1'b1;
            ST_ITEM: begin
                unique case (r_step)
                    IT_RED_SCALE: begin
                        o_ctl.a_sel = A_RED_SUM;
                        o_ctl.b_sel = B_GAIN;
                    end
                    IT_GREEN_SCALE: begin
                        o_ctl.a_sel   = A_GREEN_SUM;
                        o_ctl.b_sel   = B_GAIN;
                        o_ctl.clip_en = 1'b1;
                    end
                    IT_RED_WEIGH: begin
                        o_ctl.a_sel   = A_CLIP;
                        o_ctl.b_sel   = B_WEIGHT;
                        o_ctl.clip_en = 1'b1;
                    end
                    IT_GREEN_WEIGH: begin
                        o_ctl.a_sel  = A_CLIP;
                        o_ctl.b_sel  = B_WEIGHT;
                        o_ctl.wb_sel = WB_RED;
                    end
                    IT_BLUE_SCALE: begin
                        o_ctl.a_sel  = A_BLUE_SUM;
                        o_ctl.b_sel  = B_GAIN;
                        o_ctl.wb_sel = WB_GREEN;
                    end
                    IT_PIXELS: begin
                        o_ctl.a_sel   = A_COUNT;
                        o_ctl.b_sel   = B_WEIGHT;
                        o_ctl.clip_en = 1'b1;
                    end
                    IT_BLUE_WEIGH: begin
                        o_ctl.a_sel  = A_CLIP;
                        o_ctl.b_sel  = B_WEIGHT;
                        o_ctl.wb_sel = WB_PIXELS;
                    end
                    IT_BLUE_DONE: begin
                        o_ctl.wb_sel   = WB_BLUE;
                        o_ctl.in_ready = !i_stat.last;
                        if (i_stat.last && i_stat.wpt_zero) begin
                            o_ctl.res_zero = 1'b1;
                            o_ctl.clear    = 1'b1;
                        end
                    end
                endcase
            end
            ST_MEAN: begin
                priority case (r_step)
                    MN_WBK_MUL: begin
                        o_ctl.a_sel = A_WB;
                        o_ctl.b_sel = B_LUMA_K;
                    end
                    MN_WBK_LATCH: o_ctl.wbk_load = 1'b1;
                    MN_LO_LO: begin
                        o_ctl.a_sel    = A_TOT_LO;
                        o_ctl.b_sel    = B_WBK_LO;
                        o_ctl.acc_en   = 1'b1;
                        o_ctl.acc_load = (r_col == COL_RED);
                        o_ctl.shift    = SH_0;
                    end
                    MN_LO_HI: begin
                        o_ctl.a_sel  = A_TOT_LO;
                        o_ctl.b_sel  = B_WBK_HI;
                        o_ctl.acc_en = 1'b1;
                        o_ctl.shift  = SH_24;
                    end
                    MN_HI_LO: begin
                        o_ctl.a_sel  = A_TOT_HI;
                        o_ctl.b_sel  = B_WBK_LO;
                        o_ctl.acc_en = 1'b1;
                        o_ctl.shift  = SH_40;
                    end
                    MN_HI_HI: begin
                        o_ctl.a_sel  = A_TOT_HI;
                        o_ctl.b_sel  = B_WBK_HI;
                        o_ctl.acc_en = 1'b1;
                        o_ctl.shift  = SH_64;
                    end
                    default: o_ctl.wbk_load = 1'b0;
                endcase
            end
            ST_DRAIN: o_ctl.acc_en = 1'b0;
            ST_DIV_START: begin
                o_ctl.div_start = 1'b1;
                o_ctl.clear     = 1'b1;
            end
            ST_DIV:  o_ctl.res_div  = i_stat.div_done;
            ST_PUT:  o_ctl.out_load = i_stat.out_free;
            default: o_ctl.in_ready = 1'b0;
        endcase
    end

endmodule

@@ hdl/weighted_region_luma_meter_core.sv @@
// Weighted region luma meter, top level. Each region beat is worked through the item steps
// on the shared multiplier, and a new beat is taken in the last of them, so regions overlap.
// After the last region the totals are mixed into luma, divided by the weighted pixel count
// and loaded as the result; with zero weighted pixels the result is loaded without division.
// The result register holds its beat while the next frame's regions are accepted.
// Reset (synchronous, active low) clears the totals and sets unity gains.
module weighted_region_luma_meter_core #(
    parameter int PIXEL_BITS = 13
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // region channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [wrlm_pkg::SUM_W-1:0]         i_red_sum,
    input  logic [wrlm_pkg::SUM_W-1:0]         i_green_sum,
    input  logic [wrlm_pkg::SUM_W-1:0]         i_blue_sum,
    input  logic [wrlm_pkg::CNT_W-1:0]         i_pixel_count,
    input  logic [wrlm_pkg::WGT_W-1:0]         i_region_weight,
    input  logic                               i_last_region,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [wrlm_pkg::MEAN_W-1:0]        o_mean_luma,
    output logic                               o_no_weighted_pixels,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wrlm_pkg::ADDR_W-1:0]        paddr,
    input  logic [wrlm_pkg::DATA_W-1:0]        pwdata,
    output logic [wrlm_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import wrlm_pkg::*;

    localparam int LIM_W   = PIXEL_BITS + CNT_W;
    localparam int Y_SHIFT = WB_FRAC + PIXEL_BITS;

    t_ctrl   ctl;
    t_status stat;
    t_mac_op mac_op;

    logic [GAIN_W-1:0] r_trial_gain;
    logic [WB_W-1:0]   r_wb_red, r_wb_green, r_wb_blue;

    logic [SUM_W-1:0]  r_red_sum, r_green_sum, r_blue_sum;
    logic [CNT_W-1:0]  r_count;
    logic [WGT_W-1:0]  r_weight;
    logic              r_last;

    logic [LIM_W-1:0]     r_clip, n_clip;
    logic [WBK_W-1:0]     r_wbk;
    logic [TOT_W-1:0]     r_tot_red, r_tot_green, r_tot_blue;
    logic [PIX_TOT_W-1:0] r_wpt;
    logic [MEAN_W-1:0]    r_res_mean, r_mean;
    logic                 r_res_flag, r_flag, r_out_valid;

    logic [PROD_W-1:0]    prod;
    logic [ACC_W-1:0]     acc;
    logic                 div_done;
    logic [MEAN_W-1:0]    quot;

    logic                 capture;
    logic                 cfg_wr;
    t_reg_idx             cfg_idx;

    logic [SCALED_W-1:0]  scaled;
    logic [LIM_W-1:0]     limit;
    logic [TOT_W-1:0]     tot_mean, tot_wb, tot_sat;
    logic [TOT_W:0]       tot_sum;
    logic [PIX_TOT_W:0]   pix_sum;
    logic [PIX_TOT_W-1:0] pix_sat;
    logic [WB_W-1:0]      wb_sel;
    logic [MB_W-1:0]      k_sel;
    logic [MA_W-1:0]      op_a;
    logic [MB_W-1:0]      op_b;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trial_gain <= TRIAL_GAIN_RST;
            r_wb_red     <= WB_GAIN_RST;
            r_wb_green   <= WB_GAIN_RST;
            r_wb_blue    <= WB_GAIN_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TRIAL_GAIN: r_trial_gain <= pwdata[GAIN_W-1:0];
                REG_WB_RED:     r_wb_red     <= pwdata[WB_W-1:0];
                REG_WB_GREEN:   r_wb_green   <= pwdata[WB_W-1:0];
                REG_WB_BLUE:    r_wb_blue    <= pwdata[WB_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_TRIAL_GAIN: prdata = DATA_W'(r_trial_gain);
            REG_WB_RED:     prdata = DATA_W'(r_wb_red);
            REG_WB_GREEN:   prdata = DATA_W'(r_wb_green);
            REG_WB_BLUE:    prdata = DATA_W'(r_wb_blue);
        endcase
    end

    // sequencer
    assign stat = '{
        in_valid: i_in_valid,
        last:     r_last,
        wpt_zero: (r_wpt == '0),
        div_done: div_done,
        out_free: !r_out_valid || !i_out_stall
    };

    wrlm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    assign o_in_stall = !ctl.in_ready;
    assign capture    = ctl.in_ready && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_red_sum   <= i_red_sum;
            r_green_sum <= i_green_sum;
            r_blue_sum  <= i_blue_sum;
            r_count     <= i_pixel_count;
            r_weight    <= i_region_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b0;
        end else if (capture) begin
            r_last <= i_last_region;
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        unique case (ctl.col)
            COL_RED: begin
                tot_mean = r_tot_red;
                wb_sel   = r_wb_red;
                k_sel    = LUMA_K_RED;
            end
            COL_GREEN: begin
                tot_mean = r_tot_green;
                wb_sel   = r_wb_green;
                k_sel    = LUMA_K_GREEN;
            end
            default: begin
                tot_mean = r_tot_blue;
                wb_sel   = r_wb_blue;
                k_sel    = LUMA_K_BLUE;
            end
        endcase

        unique case (ctl.a_sel)
            A_RED_SUM:   op_a = MA_W'(r_red_sum);
            A_GREEN_SUM: op_a = MA_W'(r_green_sum);
            A_BLUE_SUM:  op_a = MA_W'(r_blue_sum);
            A_CLIP:      op_a = MA_W'(r_clip);
            A_COUNT:     op_a = MA_W'(r_count);
            A_WB:        op_a = MA_W'(wb_sel);
            A_TOT_LO:    op_a = tot_mean[MA_W-1:0];
            A_TOT_HI:    op_a = MA_W'(tot_mean[TOT_W-1:MA_W]);
        endcase

        unique case (ctl.b_sel)
            B_GAIN:   op_b = r_trial_gain;
            B_WEIGHT: op_b = MB_W'(r_weight);
            B_LUMA_K: op_b = k_sel;
            B_WBK_LO: op_b = r_wbk[WBK_LO_W-1:0];
            B_WBK_HI: op_b = MB_W'(r_wbk[WBK_W-1:WBK_LO_W]);
            default:  op_b = '0;
        endcase
    end

    assign mac_op = '{
        a:        op_a,
        b:        op_b,
        acc_en:   ctl.acc_en,
        acc_load: ctl.acc_load,
        shift:    ctl.shift
    };

    wrlm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .o_prod  (prod),
        .o_acc   (acc)
    );

    // clip the gained sum to full scale times the pixel count
    always_comb begin
        scaled = prod[GAIN_FRAC +: SCALED_W];
        limit  = (LIM_W'(r_count) << PIXEL_BITS) - LIM_W'(r_count);
        n_clip = (scaled > SCALED_W'(limit)) ? limit : scaled[LIM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (ctl.clip_en) begin
            r_clip <= n_clip;
        end
        if (ctl.wbk_load) begin
            r_wbk <= prod[WBK_W-1:0];
        end
    end

    // saturating write-back of the totals
    always_comb begin
        unique case (ctl.wb_sel)
            WB_RED:   tot_wb = r_tot_red;
            WB_GREEN: tot_wb = r_tot_green;
            default:  tot_wb = r_tot_blue;
        endcase
        tot_sum = {1'b0, tot_wb} + {1'b0, prod[TOT_W-1:0]};
        tot_sat = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
        pix_sum = {1'b0, r_wpt} + {1'b0, prod[PIX_TOT_W-1:0]};
        pix_sat = pix_sum[PIX_TOT_W] ? '1 : pix_sum[PIX_TOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctl.clear) begin
            r_tot_red   <= '0;
            r_tot_green <= '0;
            r_tot_blue  <= '0;
            r_wpt       <= '0;
        end else begin
            unique case (ctl.wb_sel)
                WB_RED:    r_tot_red   <= tot_sat;
                WB_GREEN:  r_tot_green <= tot_sat;
                WB_BLUE:   r_tot_blue  <= tot_sat;
                WB_PIXELS: r_wpt       <= pix_sat;
                default:   r_wpt       <= r_wpt;
            endcase
        end
    end

    // mean = (Y >> Y_SHIFT) / weighted pixels
    wrlm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctl.div_start),
        .i_dividend (DVD_W'(acc >> Y_SHIFT)),
        .i_divisor  (r_wpt),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.res_zero) begin
            r_res_mean <= '0;
            r_res_flag <= 1'b1;
        end else if (ctl.res_div) begin
            r_res_mean <= quot;
            r_res_flag <= 1'b0;
        end
    end

    // result register; hold until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            r_mean <= r_res_mean;
            r_flag <= r_res_flag;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_mean_luma          = r_mean;
    assign o_no_weighted_pixels = r_flag;

endmodule
